### hdl/kpl_pkg.sv
// kpl_pkg: shared types and constants of the keypad pin lock
// no dependencies; imported by keypad_pin_lock_top and kpl_step
`default_nettype none

package kpl_pkg;

  // result word event codes
  localparam logic [3:0] EV_STORED       = 4'd0;
  localparam logic [3:0] EV_GRANTED      = 4'd1;
  localparam logic [3:0] EV_DENIED       = 4'd2;
  localparam logic [3:0] EV_ADMIN_OK     = 4'd3;
  localparam logic [3:0] EV_ADMIN_BAD    = 4'd4;
  localparam logic [3:0] EV_NEW_RECORDED = 4'd5;
  localparam logic [3:0] EV_CHANGED      = 4'd6;
  localparam logic [3:0] EV_MISMATCH     = 4'd7;
  localparam logic [3:0] EV_CHANGE_REQ   = 4'd8;
  localparam logic [3:0] EV_OVERFLOW     = 4'd9;

  // lock mode state codes
  localparam logic [1:0] MODE_AUTH    = 2'd0;
  localparam logic [1:0] MODE_ADMIN   = 2'd1;
  localparam logic [1:0] MODE_NEW     = 2'd2;
  localparam logic [1:0] MODE_CONFIRM = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SUBMIT_KEY = 2'd0;
  localparam logic [1:0] CFG_CHANGE_KEY = 2'd1;
  localparam logic [1:0] CFG_ADMIN_PIN  = 2'd2;
  localparam logic [1:0] CFG_ADMIN_LEN  = 2'd3;

  localparam int ADMIN_MAX = 8;
  localparam int DEF_PIN_LEN = 4;

  // factory access pin "1234"
  localparam logic [7:0] DEF_PIN [DEF_PIN_LEN] = '{8'h31, 8'h32, 8'h33, 8'h34};

  localparam logic [7:0]  RST_SUBMIT_KEY = 8'd35;
  localparam logic [7:0]  RST_CHANGE_KEY = 8'd42;
  localparam logic [63:0] RST_ADMIN_PIN  = 64'h3030303030303030;
  localparam logic [3:0]  RST_ADMIN_LEN  = 4'd8;

  typedef struct packed {
    logic [7:0]  submit_key;
    logic [7:0]  change_key;
    logic [63:0] admin_chars;
    logic [3:0]  admin_len;
  } cfg_t;

  typedef struct packed {
    logic [3:0] event_code;
    logic [1:0] mode_after;
    logic [3:0] entry_length;
  } step_res_t;

endpackage

`default_nettype wire

### hdl/kpl_key_if.sv
// kpl_key_if: key word channel, valid/ready handshake
// no dependencies
`default_nettype none

interface kpl_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

`default_nettype wire

### hdl/kpl_evt_if.sv
// kpl_evt_if: result word channel, valid/ready handshake
// no dependencies
`default_nettype none

interface kpl_evt_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_code;
  logic [1:0] mode_after;
  logic [3:0] entry_length;

  modport source (output valid, output event_code, output mode_after,
                  output entry_length, input ready);
  modport sink   (input valid, input event_code, input mode_after,
                  input entry_length, output ready);
endinterface

`default_nettype wire

### hdl/keypad_pin_lock_top.sv
// keypad_pin_lock_top: one key word in, one result word out per key
// path: an accepted key is held in the input reg, then its result is loaded into
//   the result reg when that register is free or draining (evt_out.ready)
// throughput: 1 key per cycle while evt_out.ready is high; state update and
//   result register load happen in the same cycle, so keys follow back to back
// reset: asynchronous active low; authenticate mode, empty entry, pin "1234"
// depends on kpl_pkg, kpl_key_if, kpl_evt_if, kpl_step, kpl_match
`default_nettype none

module keypad_pin_lock_top import kpl_pkg::*; #(
  parameter int PIN_BUFFER_LEN = 9
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  kpl_key_if.sink          key_in,
  kpl_evt_if.source        evt_out,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i
);

  // entry buffer holds one char less than the pin buffer (string terminator)
  localparam int ENTRY_CAP = PIN_BUFFER_LEN - 1;

  // config registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.submit_key  <= RST_SUBMIT_KEY;
      cfg_q.change_key  <= RST_CHANGE_KEY;
      cfg_q.admin_chars <= RST_ADMIN_PIN;
      cfg_q.admin_len   <= RST_ADMIN_LEN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SUBMIT_KEY: cfg_q.submit_key  <= cfg_wdata_i[7:0];
        CFG_CHANGE_KEY: cfg_q.change_key  <= cfg_wdata_i[7:0];
        CFG_ADMIN_PIN:  cfg_q.admin_chars <= cfg_wdata_i;
        CFG_ADMIN_LEN:  cfg_q.admin_len   <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic       in_vld_q;
  logic [7:0] in_key_q;
  logic       adv;

  // the held key moves on whenever the result register is free or draining
  assign adv          = in_vld_q && (!evt_out.valid || evt_out.ready);
  assign key_in.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (key_in.ready) begin
      in_vld_q <= key_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_in.valid && key_in.ready) begin
      in_key_q <= key_in.key_code;
    end
  end

  // step logic, lock state is committed on adv
  step_res_t res;

  kpl_step #(.ENTRY_CAP(ENTRY_CAP)) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .key_i  (in_key_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // result register
  logic      out_vld_q;
  step_res_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (evt_out.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign evt_out.valid        = out_vld_q;
  assign evt_out.event_code   = out_q.event_code;
  assign evt_out.mode_after   = out_q.mode_after;
  assign evt_out.entry_length = out_q.entry_length;

endmodule

`default_nettype wire

### hdl/kpl_match.sv
// kpl_match: parallel compare of two length-tagged pin buffers
// no dependencies
`default_nettype none

module kpl_match #(
  parameter int N  = 8,
  parameter int LW = 4
) (
  input  wire logic [7:0]    a_i [N],
  input  wire logic [LW-1:0] a_len_i,
  input  wire logic [7:0]    b_i [N],
  input  wire logic [LW-1:0] b_len_i,
  output logic               eq_o
);

  logic [N-1:0] char_ok;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      // chars past the length do not count
      char_ok[i] = (LW'(i) >= a_len_i) || (a_i[i] == b_i[i]);
    end
  end

  assign eq_o = (a_len_i == b_len_i) && (&char_ok);

endmodule

`default_nettype wire

### hdl/kpl_step.sv
// kpl_step: lock state and the per-key update logic
// depends on kpl_pkg and kpl_match
`default_nettype none

module kpl_step import kpl_pkg::*; #(
  parameter int ENTRY_CAP = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       adv_i,
  input  wire logic [7:0] key_i,
  input  wire cfg_t       cfg_i,
  output step_res_t       res_o
);

  localparam int CW = $clog2(ENTRY_CAP + 1);
  localparam int LW = (CW > 3) ? CW : 3;

  logic [1:0]    mode_q, mode_d;
  logic [7:0]    entry_q [ENTRY_CAP];
  logic [7:0]    entry_d [ENTRY_CAP];
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    acc_q [ENTRY_CAP];
  logic [7:0]    acc_d [ENTRY_CAP];
  logic [LW-1:0] acc_len_q, acc_len_d;
  logic [7:0]    cand_q [ENTRY_CAP];
  logic [7:0]    cand_d [ENTRY_CAP];
  logic [LW-1:0] cand_len_q, cand_len_d;

  logic [7:0]    admin_arr [ENTRY_CAP];
  logic [3:0]    admin_len_c;
  logic          admin_fits;
  logic [LW-1:0] admin_len_m;
  logic [LW-1:0] count_ext;
  logic          auth_eq, conf_eq, admin_raw_eq, admin_eq;
  logic          is_submit, is_change, is_full, clear;
  logic [3:0]    ev;

  genvar g;
  for (g = 0; g < ENTRY_CAP; g++) begin : g_admin
    if (g < ADMIN_MAX) begin : g_byte
      assign admin_arr[g] = cfg_i.admin_chars[8*g +: 8];
    end else begin : g_zero
      assign admin_arr[g] = 8'h00;
    end
  end

  assign admin_len_c = (cfg_i.admin_len > 4'(ADMIN_MAX)) ? 4'(ADMIN_MAX) : cfg_i.admin_len;
  assign admin_fits  = (int'(admin_len_c) <= ENTRY_CAP);
  assign admin_len_m = LW'(admin_len_c);
  assign count_ext   = LW'(count_q);

  kpl_match #(.N(ENTRY_CAP), .LW(LW)) u_auth_match (
    .a_i(entry_q), .a_len_i(count_ext), .b_i(acc_q), .b_len_i(acc_len_q), .eq_o(auth_eq)
  );

  kpl_match #(.N(ENTRY_CAP), .LW(LW)) u_conf_match (
    .a_i(entry_q), .a_len_i(count_ext), .b_i(cand_q), .b_len_i(cand_len_q), .eq_o(conf_eq)
  );

  kpl_match #(.N(ENTRY_CAP), .LW(LW)) u_admin_match (
    .a_i(entry_q), .a_len_i(count_ext), .b_i(admin_arr), .b_len_i(admin_len_m),
    .eq_o(admin_raw_eq)
  );

  assign admin_eq  = admin_fits && admin_raw_eq;
  assign is_submit = (key_i == cfg_i.submit_key);
  assign is_change = !is_submit && (key_i == cfg_i.change_key);
  assign is_full   = (count_q == CW'(ENTRY_CAP));

  always_comb begin
    mode_d     = mode_q;
    entry_d    = entry_q;
    count_d    = count_q;
    acc_d      = acc_q;
    acc_len_d  = acc_len_q;
    cand_d     = cand_q;
    cand_len_d = cand_len_q;
    ev         = EV_STORED;
    clear      = 1'b0;

    if (is_submit) begin
      clear = 1'b1;
      case (mode_q)
        MODE_AUTH: begin
          ev = auth_eq ? EV_GRANTED : EV_DENIED;
        end
        MODE_ADMIN: begin
          if (admin_eq) begin
            ev     = EV_ADMIN_OK;
            mode_d = MODE_NEW;
          end else begin
            ev = EV_ADMIN_BAD;
          end
        end
        MODE_NEW: begin
          cand_d     = entry_q;
          cand_len_d = count_ext;
          ev         = EV_NEW_RECORDED;
          mode_d     = MODE_CONFIRM;
        end
        MODE_CONFIRM: begin
          if (conf_eq) begin
            acc_d     = entry_q;
            acc_len_d = count_ext;
            ev        = EV_CHANGED;
            mode_d    = MODE_AUTH;
          end else begin
            ev     = EV_MISMATCH;
            mode_d = MODE_NEW;
          end
        end
        default: begin
          mode_d = MODE_AUTH;
        end
      endcase
    end else if (is_change) begin
      clear  = 1'b1;
      ev     = EV_CHANGE_REQ;
      mode_d = MODE_ADMIN;
    end else if (is_full) begin
      clear = 1'b1;
      ev    = EV_OVERFLOW;
    end else begin
      for (int i = 0; i < ENTRY_CAP; i++) begin
        if (CW'(i) == count_q) entry_d[i] = key_i;
      end
      count_d = count_q + 1'b1;
    end

    if (clear) begin
      for (int i = 0; i < ENTRY_CAP; i++) entry_d[i] = 8'h00;
      count_d = '0;
    end

    res_o.event_code   = ev;
    res_o.mode_after   = mode_d;
    res_o.entry_length = 4'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_AUTH;
      count_q    <= '0;
      acc_len_q  <= LW'(DEF_PIN_LEN);
      cand_len_q <= '0;
      for (int i = 0; i < ENTRY_CAP; i++) begin
        entry_q[i] <= 8'h00;
        cand_q[i]  <= 8'h00;
        acc_q[i]   <= (i < DEF_PIN_LEN) ? DEF_PIN[i] : 8'h00;
      end
    end else if (adv_i) begin
      mode_q     <= mode_d;
      entry_q    <= entry_d;
      count_q    <= count_d;
      acc_q      <= acc_d;
      acc_len_q  <= acc_len_d;
      cand_q     <= cand_d;
      cand_len_q <= cand_len_d;
    end
  end

endmodule

`default_nettype wire
